/* design/p2hex_pkg.sv */
// shared constants and types for the pixel to hex cube rounding block
`timescale 1ns / 1ps

package p2hex_pkg;

  // default output coordinate width
  localparam int COORD_WIDTH_DEF = 16;

  // field and register widths
  localparam int PIX_W      = 24;
  localparam int MAT_W      = 16;
  localparam int RCP_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // fraction bits of the fractional axial values
  localparam int FRAC_BITS = 30;
  // width of the fractional axial values
  localparam int FV_W      = 60;
  // width of a rounded integer coordinate before saturation
  localparam int NI_W      = 32;

  // reset value of both reciprocals, 1.0 in Q8.16
  localparam logic [RCP_W-1:0] RCP_ONE = RCP_W'(24'h010000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_B00      = 3'd0,
    REG_INV_B01      = 3'd1,
    REG_INV_B10      = 3'd2,
    REG_INV_B11      = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_RECIP_SPAN_X = 3'd6,
    REG_RECIP_SPAN_Y = 3'd7
  } cfg_reg_t;

  // rounded coordinate and its rounding error
  typedef struct packed {
    logic signed [NI_W-1:0]      n;
    logic        [FRAC_BITS-1:0] err;
  } rnd_t;

endpackage

/* design/pixel_to_hex_cube_round_top.sv */
// pixel point to rounded hex cube coordinate pipeline
// throughput: one point per cycle while out_ready holds, set by the seven register stages that all advance together
// a stall at the output freezes every stage; nothing is lost or repeated
// reset: synchronous, clears all stage valid bits and loads matrix and origins with 0
// and both reciprocals with 1.0; data registers are not reset
`timescale 1ns / 1ps

module pixel_to_hex_cube_round_top
  import p2hex_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // input point channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [PIX_W-1:0]       pixel_x,
  input  logic signed [PIX_W-1:0]       pixel_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] cube_q,
  output logic signed [COORD_WIDTH-1:0] cube_r,
  output logic signed [COORD_WIDTH-1:0] cube_s
);

  localparam int NSTAGE = 7;
  // difference width, product width, scaled value width
  localparam int D_W    = PIX_W + 1;
  localparam int P_W    = 2 * D_W;
  localparam int U_W    = D_W + RCP_W - 8;
  // split of the scaled value for the matrix multiply
  localparam int LO_W   = 21;
  localparam int HI_W   = U_W - LO_W;
  localparam int PL_W   = MAT_W + LO_W + 1;
  localparam int PH_W   = MAT_W + HI_W;
  // rebuild width
  localparam int RB_W   = NI_W + 2;

  localparam logic signed [RB_W-1:0] SAT_HI = RB_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RB_W-1:0] SAT_LO = -SAT_HI - RB_W'(1);
  localparam logic [FRAC_BITS-1:0]   HALF_ERR = FRAC_BITS'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [MAT_W-1:0] inv_b00, inv_b01, inv_b10, inv_b11;
  logic signed [PIX_W-1:0] origin_x, origin_y;
  logic        [RCP_W-1:0] recip_span_x, recip_span_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_b00      <= '0;
      inv_b01      <= '0;
      inv_b10      <= '0;
      inv_b11      <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      recip_span_x <= RCP_ONE;
      recip_span_y <= RCP_ONE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_B00:      inv_b00      <= cfg_data[MAT_W-1:0];
        REG_INV_B01:      inv_b01      <= cfg_data[MAT_W-1:0];
        REG_INV_B10:      inv_b10      <= cfg_data[MAT_W-1:0];
        REG_INV_B11:      inv_b11      <= cfg_data[MAT_W-1:0];
        REG_ORIGIN_X:     origin_x     <= cfg_data[PIX_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[PIX_W-1:0];
        REG_RECIP_SPAN_X: recip_span_x <= cfg_data[RCP_W-1:0];
        REG_RECIP_SPAN_Y: recip_span_y <= cfg_data[RCP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves when the output register can take
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld;
  logic              adv;

  assign adv       = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // round half away from zero, with the distance to the chosen integer
  function automatic rnd_t round_err(input logic signed [FV_W-1:0] v);
    logic [FV_W-1:0]      mag;
    logic [FRAC_BITS-1:0] f;
    logic [NI_W-1:0]      n_mag;
    rnd_t                 res;
    mag   = v[FV_W-1] ? FV_W'(-v) : FV_W'(v);
    f     = mag[FRAC_BITS-1:0];
    n_mag = NI_W'(mag[FV_W-1:FRAC_BITS]) + NI_W'(mag[FRAC_BITS-1]);
    res.n = v[FV_W-1] ? -$signed(n_mag) : $signed(n_mag);
    if (mag[FRAC_BITS-1]) begin
      res.err = FRAC_BITS'((FRAC_BITS+1)'(1) << FRAC_BITS) - f;
    end else begin
      res.err = f;
    end
    return res;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [RB_W-1:0] v);
    logic signed [RB_W-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[COORD_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stage 1: subtract the layout origin
  // ---------------------------------------------------------------------------
  logic signed [D_W-1:0] s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= D_W'(pixel_x) - D_W'(origin_x);
      s1_dy <= D_W'(pixel_y) - D_W'(origin_y);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: scale by the reciprocal span
  // ---------------------------------------------------------------------------
  logic signed [P_W-1:0] s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px <= P_W'(s1_dx) * P_W'($signed({1'b0, recip_span_x}));
      s2_py <= P_W'(s1_dy) * P_W'($signed({1'b0, recip_span_y}));
    end
  end

  // floor of the product over 2^8
  logic signed [U_W-1:0] ux, uy;
  assign ux = s2_px[U_W+7:8];
  assign uy = s2_py[U_W+7:8];

  // ---------------------------------------------------------------------------
  // stage 3: matrix partial products, each scaled value split low and high
  // ---------------------------------------------------------------------------
  logic signed [PL_W-1:0] s3_qxl, s3_qyl, s3_rxl, s3_ryl;
  logic signed [PH_W-1:0] s3_qxh, s3_qyh, s3_rxh, s3_ryh;
  logic signed [LO_W:0]   ux_lo, uy_lo;
  logic signed [HI_W-1:0] ux_hi, uy_hi;

  assign ux_lo = $signed({1'b0, ux[LO_W-1:0]});
  assign uy_lo = $signed({1'b0, uy[LO_W-1:0]});
  assign ux_hi = ux[U_W-1:LO_W];
  assign uy_hi = uy[U_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_qxl <= PL_W'(inv_b00) * PL_W'(ux_lo);
      s3_qyl <= PL_W'(inv_b01) * PL_W'(uy_lo);
      s3_rxl <= PL_W'(inv_b10) * PL_W'(ux_lo);
      s3_ryl <= PL_W'(inv_b11) * PL_W'(uy_lo);
      s3_qxh <= PH_W'(inv_b00) * PH_W'(ux_hi);
      s3_qyh <= PH_W'(inv_b01) * PH_W'(uy_hi);
      s3_rxh <= PH_W'(inv_b10) * PH_W'(ux_hi);
      s3_ryh <= PH_W'(inv_b11) * PH_W'(uy_hi);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: fractional axial q and r, Q.30
  // ---------------------------------------------------------------------------
  logic signed [FV_W-1:0] s4_fq, s4_fr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_fq <= (FV_W'(s3_qxh) <<< LO_W) + FV_W'(s3_qxl)
             + (FV_W'(s3_qyh) <<< LO_W) + FV_W'(s3_qyl);
      s4_fr <= (FV_W'(s3_rxh) <<< LO_W) + FV_W'(s3_rxl)
             + (FV_W'(s3_ryh) <<< LO_W) + FV_W'(s3_ryl);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: third cube component
  // ---------------------------------------------------------------------------
  logic signed [FV_W-1:0] s5_fq, s5_fr, s5_fs;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_fq <= s4_fq;
      s5_fr <= s4_fr;
      s5_fs <= -s4_fq - s4_fr;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: round each component and keep its error
  // ---------------------------------------------------------------------------
  rnd_t s6_q, s6_r, s6_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_q <= round_err(s5_fq);
      s6_r <= round_err(s5_fr);
      s6_s <= round_err(s5_fs);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: rebuild the worst component, saturate into the output register
  // ---------------------------------------------------------------------------
  logic signed [RB_W-1:0] nq, nr, ns;
  logic signed [RB_W-1:0] bq, br, bs;

  assign nq = RB_W'(s6_q.n);
  assign nr = RB_W'(s6_r.n);
  assign ns = RB_W'(s6_s.n);

  always_comb begin
    bq = nq;
    br = nr;
    bs = ns;
    if (s6_q.err > s6_r.err && s6_q.err > s6_s.err) begin
      bq = -nr - ns;
    end else if (s6_r.err > s6_s.err) begin
      br = -nq - ns;
    end else begin
      bs = -nq - nr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cube_q <= sat(bq);
      cube_r <= sat(br);
      cube_s <= sat(bs);
    end
  end

`ifndef SYNTH
  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits not cleared by reset");

  // a stall freezes the stage valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld == $past(vld))
    else $error("stage valid bits moved during a stall");

  // rounding error never exceeds one half
  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] |-> (s6_q.err <= HALF_ERR && s6_r.err <= HALF_ERR
                       && s6_s.err <= HALF_ERR))
    else $error("rounding error above one half");

  // rebuilt cube coordinates always sum to zero
  a_cube_sum: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] |-> (bq + br + bs) == '0)
    else $error("rebuilt cube coordinates do not sum to zero");
`endif

endmodule
